/* hw/rtl/camera_pixel_format_converter_assert.svh */
// Assertion macros shared by the pixel format converter RTL.
`ifndef CAMERA_PIXEL_FORMAT_CONVERTER_ASSERT_SVH
`define CAMERA_PIXEL_FORMAT_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define CPFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpfc: same-cycle check failed");
// Next-cycle implication, checked on every clock edge outside reset.
`define CPFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpfc: next-cycle check failed");
`else
`define CPFC_ASSERT_IMP(lbl, ante, cons)
`define CPFC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/cpfc_pkg.sv */
// Types and constants of the camera pixel format converter.
`default_nettype none
package cpfc_pkg;

  // Input format codes held in the format register.
  typedef enum logic [1:0] {
    FMT_RGB24 = 2'd0,
    FMT_BGR24 = 2'd1,
    FMT_YUYV  = 2'd2,
    FMT_RSVD  = 2'd3
  } fmt_t;

  // One input word: four bytes of camera data.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
  } in_word_t;

  // One output word: an RGB888 pixel with its luma.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] gray;
    logic       last_of_item;
  } out_word_t;

  // One pixel operation from the splitter to the arithmetic pipeline.
  // In RGB modes the bytes are R, G, B; in YUYV mode they are Y, U, V.
  typedef struct packed {
    logic       is_yuv;
    logic       last;
    logic [7:0] y_r;
    logic [7:0] u_g;
    logic [7:0] v_b;
  } pix_op_t;

  // Width of the signed channel sums, wide enough for every BT.601 term.
  localparam int unsigned SUM_W  = 20;
  // Width of the unsigned luma sum.
  localparam int unsigned LUMA_W = 16;

  // BT.601 integer coefficients and offsets.
  localparam logic signed [SUM_W-1:0] K_Y   = SUM_W'(298);
  localparam logic signed [SUM_W-1:0] K_RV  = SUM_W'(409);
  localparam logic signed [SUM_W-1:0] K_GU  = SUM_W'(100);
  localparam logic signed [SUM_W-1:0] K_GV  = SUM_W'(208);
  localparam logic signed [SUM_W-1:0] K_BU  = SUM_W'(516);
  localparam logic signed [SUM_W-1:0] K_RND = SUM_W'(128);
  localparam logic signed [9:0]       Y_OFS = 10'sd16;
  localparam logic signed [9:0]       C_OFS = 10'sd128;

  // Luma weights for RGB input.
  localparam logic [LUMA_W-1:0] K_LR = LUMA_W'(77);
  localparam logic [LUMA_W-1:0] K_LG = LUMA_W'(150);
  localparam logic [LUMA_W-1:0] K_LB = LUMA_W'(29);

endpackage
`default_nettype wire

/* hw/rtl/camera_pixel_format_converter.sv */
// Top level of the camera pixel format converter.
// Converts camera words into RGB888 pixels with an 8-bit gray value. The format
// register selects RGB24, BGR24 or packed YUYV; write it only while no word is in
// flight. RGB24 and BGR24 words give one pixel each and are taken one per cycle
// while the pipeline does not stall. A YUYV word gives two BT.601 pixels (Y0
// first, then Y1 flagged last_of_item), one after the other, because the input
// stage issues one pixel per cycle into the arithmetic pipeline. Words that
// arrive with the unused format code are taken and dropped. An accepted word
// is first held in the input stage; its pixel operations are then registered
// as products, then as sums, and then clipped or passed into the output register.
// Back-pressure stalls the pipeline without losing or repeating a word.
`default_nettype none
module camera_pixel_format_converter (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [1:0]          cfg_data,
  input  wire                 in_valid,
  output logic                in_ready,
  input  cpfc_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output cpfc_pkg::out_word_t out_data
);
  import cpfc_pkg::*;

  fmt_t    pixel_format;
  logic    op_valid;
  logic    op_ready;
  pix_op_t op;

  // Format register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_RGB24;
    end else if (cfg_valid) begin
      pixel_format <= fmt_t'(cfg_data);
    end
  end

  // Input stage: one or two pixel operations per word, none for the unused format.
  cpfc_split u_split (
    .clk      (clk),
    .rst      (rst),
    .fmt      (pixel_format),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  // Arithmetic pipeline and output register.
  cpfc_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* hw/rtl/cpfc_split.sv */
// Input stage: holds one input word and issues one or two pixel operations (none for the unused format).
`default_nettype none
`include "camera_pixel_format_converter_assert.svh"
module cpfc_split (
  input  wire                clk,
  input  wire                rst,
  input  cpfc_pkg::fmt_t     fmt,
  input  wire                in_valid,
  output logic               in_ready,
  input  cpfc_pkg::in_word_t in_data,
  output logic               op_valid,
  input  wire                op_ready,
  output cpfc_pkg::pix_op_t  op
);
  import cpfc_pkg::*;

  logic     hold_v;
  logic     phase;
  in_word_t hold;
  fmt_t     hold_fmt;
  logic     done;
  logic     take;

  // Build the pixel operation for the current phase of the held word.
  always_comb begin
    op       = '0;
    op_valid = hold_v;
    unique case (hold_fmt)
      FMT_YUYV: begin
        op.is_yuv = 1'b1;
        op.last   = phase;
        op.y_r    = phase ? hold.byte2 : hold.byte0;
        op.u_g    = hold.byte1;
        op.v_b    = hold.byte3;
      end
      FMT_BGR24: begin
        op.last = 1'b1;
        op.y_r  = hold.byte2;
        op.u_g  = hold.byte1;
        op.v_b  = hold.byte0;
      end
      FMT_RGB24, FMT_RSVD: begin
        op.last = 1'b1;
        op.y_r  = hold.byte0;
        op.u_g  = hold.byte1;
        op.v_b  = hold.byte2;
      end
      default: begin
        op.last = 1'b1;
      end
    endcase
  end

  // The held word is finished once its last pixel leaves.
  assign done     = hold_v && op_ready && op.last;
  assign in_ready = !hold_v || done;
  assign take     = in_valid && in_ready;

  // Control state: word valid and YUYV phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      phase  <= 1'b0;
    end else if (take) begin
      // Words in the unused format are consumed and dropped.
      hold_v <= (fmt != FMT_RSVD);
      phase  <= 1'b0;
    end else if (done) begin
      hold_v <= 1'b0;
      phase  <= 1'b0;
    end else if (hold_v && op_ready) begin
      phase <= 1'b1;
    end
  end

  // Payload of the held word.
  always_ff @(posedge clk) begin
    if (take) begin
      hold     <= in_data;
      hold_fmt <= fmt;
    end
  end

  // The second pixel only exists for a held YUYV word.
  `CPFC_ASSERT_IMP(a_phase_yuv, phase, hold_v && (hold_fmt == FMT_YUYV))
  // A stalled pixel operation is offered again unchanged.
  `CPFC_ASSERT_NXT(a_op_hold, op_valid && !op_ready, op_valid && $stable(op))

endmodule
`default_nettype wire

/* hw/rtl/cpfc_pipe.sv */
// Arithmetic pipeline: products, channel sums, then clipping into the output register.
`default_nettype none
`include "camera_pixel_format_converter_assert.svh"
module cpfc_pipe (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 op_valid,
  output logic                op_ready,
  input  cpfc_pkg::pix_op_t   op,
  output logic                out_valid,
  input  wire                 out_ready,
  output cpfc_pkg::out_word_t out_data
);
  import cpfc_pkg::*;

  // Product stage contents.
  typedef struct packed {
    logic                    is_yuv;
    logic                    last;
    logic [7:0]              y_r;
    logic [7:0]              u_g;
    logic [7:0]              v_b;
    logic signed [SUM_W-1:0] m_y;
    logic signed [SUM_W-1:0] m_rv;
    logic signed [SUM_W-1:0] m_gu;
    logic signed [SUM_W-1:0] m_gv;
    logic signed [SUM_W-1:0] m_bu;
    logic [LUMA_W-1:0]       m_lr;
    logic [LUMA_W-1:0]       m_lg;
    logic [LUMA_W-1:0]       m_lb;
  } prod_t;

  // Sum stage contents.
  typedef struct packed {
    logic                    is_yuv;
    logic                    last;
    logic [7:0]              y_r;
    logic [7:0]              u_g;
    logic [7:0]              v_b;
    logic signed [SUM_W-1:0] s_r;
    logic signed [SUM_W-1:0] s_g;
    logic signed [SUM_W-1:0] s_b;
    logic [7:0]              luma;
  } sum_t;

  // Shift a channel sum down by eight and clip it to 0..255.
  function automatic logic [7:0] clip8(input logic signed [SUM_W-1:0] s);
    logic [7:0] res;
    if (s[SUM_W-1]) begin
      res = 8'd0;
    end else if (|s[SUM_W-2:16]) begin
      res = 8'hFF;
    end else begin
      res = s[15:8];
    end
    return res;
  endfunction

  logic            v1;
  logic            v2;
  logic            vo;
  logic            adv1;
  logic            adv2;
  logic            advo;
  prod_t           p1;
  prod_t           p1_next;
  sum_t            s2;
  sum_t            s2_next;
  out_word_t       ow;
  out_word_t       ow_next;
  logic signed [9:0] c;
  logic signed [9:0] d;
  logic signed [9:0] e;
  logic [LUMA_W-1:0] luma_sum;

  // Stall chain: a stage moves when it is empty or the stage after it moves.
  assign advo     = !vo || out_ready;
  assign adv2     = !v2 || advo;
  assign adv1     = !v1 || adv2;
  assign op_ready = adv1;

  // First stage: offsets removed and all coefficient products formed.
  always_comb begin
    c = $signed({2'b00, op.y_r}) - Y_OFS;
    d = $signed({2'b00, op.u_g}) - C_OFS;
    e = $signed({2'b00, op.v_b}) - C_OFS;
    p1_next.is_yuv = op.is_yuv;
    p1_next.last   = op.last;
    p1_next.y_r    = op.y_r;
    p1_next.u_g    = op.u_g;
    p1_next.v_b    = op.v_b;
    p1_next.m_y    = SUM_W'(c) * K_Y;
    p1_next.m_rv   = SUM_W'(e) * K_RV;
    p1_next.m_gu   = SUM_W'(d) * K_GU;
    p1_next.m_gv   = SUM_W'(e) * K_GV;
    p1_next.m_bu   = SUM_W'(d) * K_BU;
    p1_next.m_lr   = LUMA_W'(op.y_r) * K_LR;
    p1_next.m_lg   = LUMA_W'(op.u_g) * K_LG;
    p1_next.m_lb   = LUMA_W'(op.v_b) * K_LB;
  end

  // Second stage: channel sums with rounding, and the RGB luma.
  always_comb begin
    luma_sum       = p1.m_lr + p1.m_lg + p1.m_lb;
    s2_next.is_yuv = p1.is_yuv;
    s2_next.last   = p1.last;
    s2_next.y_r    = p1.y_r;
    s2_next.u_g    = p1.u_g;
    s2_next.v_b    = p1.v_b;
    s2_next.s_r    = p1.m_y + p1.m_rv + K_RND;
    s2_next.s_g    = p1.m_y - p1.m_gu - p1.m_gv + K_RND;
    s2_next.s_b    = p1.m_y + p1.m_bu + K_RND;
    s2_next.luma   = luma_sum[LUMA_W-1:8];
  end

  // Third stage: clip YUV channels or pass RGB bytes, pick the gray value.
  always_comb begin
    ow_next.last_of_item = s2.last;
    if (s2.is_yuv) begin
      ow_next.red   = clip8(s2.s_r);
      ow_next.green = clip8(s2.s_g);
      ow_next.blue  = clip8(s2.s_b);
      ow_next.gray  = s2.y_r;
    end else begin
      ow_next.red   = s2.y_r;
      ow_next.green = s2.u_g;
      ow_next.blue  = s2.v_b;
      ow_next.gray  = s2.luma;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= op_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (advo) begin
        vo <= v2;
      end
    end
  end

  // Stage payloads, loaded only with a valid word.
  always_ff @(posedge clk) begin
    if (adv1 && op_valid) begin
      p1 <= p1_next;
    end
    if (adv2 && v1) begin
      s2 <= s2_next;
    end
    if (advo && v2) begin
      ow <= ow_next;
    end
  end

  assign out_valid = vo;
  assign out_data  = ow;

  // A held sum stage keeps its word while the output is blocked.
  `CPFC_ASSERT_NXT(a_s2_hold, v2 && !adv2, v2 && $stable(s2))
  // An RGB pixel is always the last pixel of its word.
  `CPFC_ASSERT_IMP(a_rgb_last, v2 && !s2.is_yuv, s2.last)

endmodule
`default_nettype wire

/* bench/tb_camera_pixel_format_converter.sv */
// Testbench for the camera pixel format converter: directed and random words with a scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module tb_camera_pixel_format_converter;
  import cpfc_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1650;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned STALL_LIMIT  = 4000;

  // Scoreboard: predicts the pixels of each accepted word and checks the output words in order.
  class pixel_scoreboard;
    fmt_t      fmt;
    out_word_t pixel_q[$];
    int        errors;

    function new();
      fmt    = FMT_RGB24;
      errors = 0;
    endfunction

    // Rounded channel sum, floor shift by 8, clipped to 0..255.
    function logic [7:0] clip_channel(int sum);
      if (sum < 0) begin
        return 8'd0;
      end
      if ((sum >>> 8) > 255) begin
        return 8'd255;
      end
      return 8'(sum >>> 8);
    endfunction

    // One BT.601 pixel from a luma byte and the shared chroma pair.
    function out_word_t yuv_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v, logic last);
      out_word_t px;
      int c;
      int d;
      int e;
      c = int'(y) - 16;
      d = int'(u) - 128;
      e = int'(v) - 128;
      px.red          = clip_channel(298 * c + 409 * e + 128);
      px.green        = clip_channel(298 * c - 100 * d - 208 * e + 128);
      px.blue         = clip_channel(298 * c + 516 * d + 128);
      px.gray         = y;
      px.last_of_item = last;
      return px;
    endfunction

    // Notes an accepted input word and queues the pixels it should produce.
    function void note_input(in_word_t w);
      out_word_t px;
      int luma;
      case (fmt)
        FMT_RGB24, FMT_BGR24: begin
          px.red          = (fmt == FMT_RGB24) ? w.byte0 : w.byte2;
          px.green        = w.byte1;
          px.blue         = (fmt == FMT_RGB24) ? w.byte2 : w.byte0;
          luma            = 77 * int'(px.red) + 150 * int'(px.green) + 29 * int'(px.blue);
          px.gray         = 8'(luma >> 8);
          px.last_of_item = 1'b1;
          pixel_q.push_back(px);
        end
        FMT_YUYV: begin
          pixel_q.push_back(yuv_pixel(w.byte0, w.byte1, w.byte3, 1'b0));
          pixel_q.push_back(yuv_pixel(w.byte2, w.byte1, w.byte3, 1'b1));
        end
        default: begin
          // The unused format code drops the word.
        end
      endcase
    endfunction

    function void report_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Checks one output word against the oldest predicted pixel.
    function void check_result(out_word_t got);
      out_word_t want;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected output word: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pixel_q.pop_front();
      if ($isunknown(got)) begin
        $display("%0t: unknown bits in output: expected %h, actual %h", $time, want, got);
        errors++;
        return;
      end
      report_field("red", want.red, got.red);
      report_field("green", want.green, got.green);
      report_field("blue", want.blue, got.blue);
      report_field("gray", want.gray, got.gray);
      report_field("last_of_item", want.last_of_item, got.last_of_item);
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data  = 2'd0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_word_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_data;

  // When set, neither side idles.
  logic calm = 1'b0;
  int   stall_cycles = 0;

  pixel_scoreboard board = new();

  camera_pixel_format_converter u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stalls now and then unless the calm stretch is on.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 7);
  end

  // Output monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_result(out_data);
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Presents one input word, with an occasional gap first, and waits for its acceptance.
  task automatic send_word(in_word_t w);
    if (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(w);
  endtask

  // Waits for the pipeline to drain, then writes the format register.
  task automatic set_format(fmt_t f);
    in_valid <= 1'b0;
    while (board.pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= f;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.fmt = f;
  endtask

  // Random byte that favors the extremes.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int   counted;
    int   phase_no;
    int   n;
    fmt_t f;

    counted  = 0;
    phase_no = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed words in the reset format, RGB24: extremes and each primary.
    send_word({8'd0, 8'd0, 8'd0, 8'd0});
    send_word({8'd255, 8'd255, 8'd255, 8'd255});
    send_word({8'd255, 8'd0, 8'd0, 8'd170});
    send_word({8'd0, 8'd255, 8'd0, 8'd85});
    send_word({8'd0, 8'd0, 8'd255, 8'd0});

    // BGR24 swaps the outer bytes.
    set_format(FMT_BGR24);
    send_word({8'd255, 8'd0, 8'd128, 8'd7});
    send_word({8'd0, 8'd255, 8'd255, 8'd0});
    send_word({8'd17, 8'd34, 8'd51, 8'd255});

    // YUYV: clipping below zero and above 255, nominal black and white, chroma extremes.
    set_format(FMT_YUYV);
    send_word({8'd0, 8'd0, 8'd255, 8'd0});
    send_word({8'd255, 8'd255, 8'd0, 8'd255});
    send_word({8'd16, 8'd128, 8'd235, 8'd128});
    send_word({8'd0, 8'd128, 8'd255, 8'd128});
    send_word({8'd128, 8'd0, 8'd128, 8'd255});
    send_word({8'd128, 8'd255, 8'd128, 8'd0});

    // The unused format code: words are taken and dropped.
    set_format(FMT_RSVD);
    send_word({8'd255, 8'd255, 8'd255, 8'd255});
    send_word({8'd1, 8'd2, 8'd3, 8'd4});

    // Random phases in random formats; one long YUYV phase runs without idling.
    while (counted < RANDOM_WORDS) begin
      if (phase_no == 2) begin
        f = FMT_YUYV;
        n = 200;
      end else begin
        f = fmt_t'($urandom_range(0, 3));
        n = (f == FMT_RSVD) ? $urandom_range(1, 4) : $urandom_range(40, 160);
      end
      calm <= (phase_no == 2);
      set_format(f);
      repeat (n) send_word({rand_byte(), rand_byte(), rand_byte(), rand_byte()});
      if (f != FMT_RSVD) begin
        counted += n;
      end
      phase_no++;
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    // Let every predicted pixel arrive, then watch for strays.
    while (board.pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
